/* src/mbd_pkg.sv */
package mbd_pkg;

  // Deframer phases.
  typedef enum logic [2:0] {
    PH_OPEN    = 3'd0,
    PH_AFTER   = 3'd1,
    PH_CLOSE   = 3'd2,
    PH_LF      = 3'd3,
    PH_HDR     = 3'd4,
    PH_HDR_LF  = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_STOP    = 3'd7
  } phase_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_START = 3'd1,
    EV_END   = 3'd2,
    EV_DONE  = 3'd3,
    EV_ERROR = 3'd4
  } ev_kind_t;

  // Register indexes on the configuration port (byte address is 8 * index).
  localparam logic [2:0] REG_LEN = 3'd0;
  localparam logic [2:0] REG_W0  = 3'd1;
  localparam logic [2:0] REG_W1  = 3'd2;
  localparam logic [2:0] REG_W2  = 3'd3;
  localparam logic [2:0] REG_W3  = 3'd4;
  localparam logic [2:0] REG_W4  = 3'd5;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  localparam int BND_WORDS        = 5;
  localparam int BND_BYTES        = 40;
  localparam int DEF_MAX_BOUNDARY = 40;

  // Cap on a released run of held bytes: CR LF "--" and the boundary.
  localparam logic [5:0] REL_MAX = 6'(BND_BYTES + 4);

endpackage

/* src/multipart_body_deframer_core.sv */
// Byte-serial multipart/form-data body deframer.
// Input channel (in_valid / in_stall / in_body_byte): one body byte per transfer.
// Result channel (out_valid / out_stall / out_event_kind, out_payload_byte, out_last):
// payload bytes, part start, part end, stream done and format error events;
// out_last marks the final result caused by one input byte.
// Configuration is an APB-style port with 64-bit data; register i is at byte address 8*i
// (boundary length, then five words of boundary bytes, first byte in the low bits).
// A result is registered in the output register, or in the skid register when it is full.
// Throughput: one byte per cycle while in_stall is low. A byte that breaks a partial
// delimiter match releases the k held bytes (at most 44) plus possibly itself, one result
// per cycle while the skid register is empty; the release sequencer holds in_stall high
// until the last of them has been presented.
// The result side has an output register and a skid register, so a byte is still
// taken while one result waits; in_stall rises once the skid register is occupied.
// Reset (rst_n low, synchronous) returns the block to the opening boundary check, sets
// the boundary length to 1 and clears the boundary words. After stream done or a format
// error the block consumes bytes with no results until the next reset.
module multipart_body_deframer_core #(
  parameter int MAX_BOUNDARY = mbd_pkg::DEF_MAX_BOUNDARY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_body_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mbd_pkg::*;

  localparam logic [5:0] MaxLen   = 6'(MAX_BOUNDARY);
  localparam logic [5:0] BndLimit = 6'(BND_BYTES);

  // Configuration registers.
  logic [5:0]  len_r;
  logic [63:0] bnd_w_r [BND_WORDS];

  // Deframer state.
  phase_t      phase_r, phase_nxt;
  logic [5:0]  match_r, match_nxt;
  logic        lht_r, lht_nxt;

  // Release sequencer.
  logic        rel_active_r, rel_active_nxt;
  logic [5:0]  rel_idx_r, rel_idx_nxt;
  logic [5:0]  rel_end_r, rel_end_nxt;
  logic        rel_tail_r, rel_tail_nxt;
  logic [7:0]  rel_byte_r, rel_byte_nxt;

  // Output and skid registers.
  logic        out_valid_r, skid_valid_r;
  ev_kind_t    out_kind_r, skid_kind_r;
  logic [7:0]  out_byte_r, skid_byte_r;
  logic        out_last_r, skid_last_r;

  // Result of this cycle.
  logic        res_valid;
  ev_kind_t    res_kind;
  logic [7:0]  res_byte;
  logic        res_last;

  logic        cfg_wr;
  logic        in_acc, rel_go, out_take;
  logic [7:0]  b;
  logic [5:0]  eff_len;
  logic [5:0]  sel_pos, bidx, match_inc, rel_idx_inc, held_n;
  logic [63:0] bword;
  logic [7:0]  bnd_byte, pat_byte;
  logic        is_open, hit, open_done, delim_done;
  logic        rel_more, rel_final, start_tail, start_final;

  // ---------------------------------------------------------------- configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 6'd1;
      for (int i = 0; i < BND_WORDS; i++) begin
        bnd_w_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_LEN: len_r      <= pwdata[5:0];
        REG_W0:  bnd_w_r[0] <= pwdata;
        REG_W1:  bnd_w_r[1] <= pwdata;
        REG_W2:  bnd_w_r[2] <= pwdata;
        REG_W3:  bnd_w_r[3] <= pwdata;
        REG_W4:  bnd_w_r[4] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_LEN: prdata = {58'd0, len_r};
      REG_W0:  prdata = bnd_w_r[0];
      REG_W1:  prdata = bnd_w_r[1];
      REG_W2:  prdata = bnd_w_r[2];
      REG_W3:  prdata = bnd_w_r[3];
      REG_W4:  prdata = bnd_w_r[4];
      default: prdata = '0;
    endcase
  end

  always_comb begin
    if (len_r == 6'd0) begin
      eff_len = 6'd1;
    end else if (len_r > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = len_r;
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign in_stall = rel_active_r || skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign rel_go   = rel_active_r && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign b        = in_body_byte;

  // ---------------------------------------------------------------- pattern lookup
  // Input and release never share a cycle, so one boundary byte lookup serves both.
  assign is_open = (phase_r == PH_OPEN);
  assign sel_pos = rel_active_r ? rel_idx_r : match_r;
  assign bidx    = sel_pos - (is_open ? 6'd2 : 6'd4);

  always_comb begin
    unique case (bidx[5:3])
      3'd0:    bword = bnd_w_r[0];
      3'd1:    bword = bnd_w_r[1];
      3'd2:    bword = bnd_w_r[2];
      3'd3:    bword = bnd_w_r[3];
      3'd4:    bword = bnd_w_r[4];
      default: bword = '0;
    endcase
    if (bidx < BndLimit && bidx < MaxLen) begin
      bnd_byte = bword[{bidx[2:0], 3'b000} +: 8];
    end else begin
      bnd_byte = 8'd0;
    end
  end

  always_comb begin
    if (is_open) begin
      pat_byte = (sel_pos < 6'd2) ? CHAR_DASH : bnd_byte;
    end else begin
      unique case (sel_pos)
        6'd0:       pat_byte = CHAR_CR;
        6'd1:       pat_byte = CHAR_LF;
        6'd2, 6'd3: pat_byte = CHAR_DASH;
        default:    pat_byte = bnd_byte;
      endcase
    end
  end

  assign hit        = (b == pat_byte);
  assign match_inc  = match_r + 6'd1;
  assign open_done  = {1'b0, match_inc} >= ({1'b0, eff_len} + 7'd2);
  assign delim_done = {1'b0, match_inc} >= ({1'b0, eff_len} + 7'd4);

  // A failed delimiter releases the held bytes; the failing byte follows unless it is CR.
  assign held_n      = (match_r > REL_MAX) ? REL_MAX : match_r;
  assign start_tail  = (b != CHAR_CR);
  assign start_final = (held_n == 6'd1) && !start_tail;

  assign rel_idx_inc = rel_idx_r + 6'd1;
  assign rel_more    = rel_idx_r < rel_end_r;
  assign rel_final   = rel_more ? ((rel_idx_inc == rel_end_r) && !rel_tail_r) : 1'b1;

  // ---------------------------------------------------------------- next state
  always_comb begin
    phase_nxt      = phase_r;
    match_nxt      = match_r;
    lht_nxt        = lht_r;
    rel_active_nxt = rel_active_r;
    rel_idx_nxt    = rel_idx_r;
    rel_end_nxt    = rel_end_r;
    rel_tail_nxt   = rel_tail_r;
    rel_byte_nxt   = rel_byte_r;
    if (rel_go) begin
      if (rel_more) begin
        rel_idx_nxt = rel_idx_inc;
      end
      if (rel_final) begin
        rel_active_nxt = 1'b0;
      end
    end else if (in_acc) begin
      unique case (phase_r)
        PH_OPEN: begin
          if (!hit) begin
            phase_nxt = PH_STOP;
          end else if (open_done) begin
            match_nxt = 6'd0;
            phase_nxt = PH_AFTER;
          end else begin
            match_nxt = match_inc;
          end
        end
        PH_AFTER: begin
          if (b == CHAR_DASH) begin
            phase_nxt = PH_CLOSE;
          end else if (b == CHAR_CR) begin
            phase_nxt = PH_LF;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_CLOSE: phase_nxt = PH_STOP;
        PH_LF: begin
          if (b == CHAR_LF) begin
            lht_nxt   = 1'b0;
            phase_nxt = PH_HDR;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_HDR: begin
          if (b == CHAR_CR) begin
            phase_nxt = PH_HDR_LF;
          end else begin
            lht_nxt = 1'b1;
          end
        end
        PH_HDR_LF: begin
          if (b == CHAR_LF) begin
            if (!lht_r) begin
              match_nxt = 6'd0;
              phase_nxt = PH_PAYLOAD;
            end else begin
              lht_nxt   = 1'b0;
              phase_nxt = PH_HDR;
            end
          end else begin
            // The earlier CR was ordinary header text.
            lht_nxt = 1'b1;
            if (b != CHAR_CR) begin
              phase_nxt = PH_HDR;
            end
          end
        end
        PH_PAYLOAD: begin
          if (hit) begin
            if (delim_done) begin
              match_nxt = 6'd0;
              phase_nxt = PH_AFTER;
            end else begin
              match_nxt = match_inc;
            end
          end else begin
            match_nxt = start_tail ? 6'd0 : 6'd1;
            if (match_r != 6'd0) begin
              rel_active_nxt = !start_final;
              rel_idx_nxt    = 6'd1;
              rel_end_nxt    = held_n;
              rel_tail_nxt   = start_tail;
              rel_byte_nxt   = b;
            end
          end
        end
        PH_STOP: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- results
  always_comb begin
    res_valid = 1'b0;
    res_kind  = EV_DATA;
    res_byte  = 8'd0;
    res_last  = 1'b1;
    if (rel_go) begin
      res_valid = 1'b1;
      res_byte  = rel_more ? pat_byte : rel_byte_r;
      res_last  = rel_final;
    end else if (in_acc) begin
      unique case (phase_r)
        PH_OPEN: begin
          if (!hit) begin
            res_valid = 1'b1;
            res_kind  = EV_ERROR;
          end
        end
        PH_AFTER: begin
          if (b != CHAR_DASH && b != CHAR_CR) begin
            res_valid = 1'b1;
            res_kind  = EV_ERROR;
          end
        end
        PH_CLOSE: begin
          res_valid = 1'b1;
          res_kind  = (b == CHAR_DASH) ? EV_DONE : EV_ERROR;
        end
        PH_LF: begin
          if (b != CHAR_LF) begin
            res_valid = 1'b1;
            res_kind  = EV_ERROR;
          end
        end
        PH_HDR: ;
        PH_HDR_LF: begin
          if (b == CHAR_LF && !lht_r) begin
            res_valid = 1'b1;
            res_kind  = EV_START;
          end
        end
        PH_PAYLOAD: begin
          if (hit) begin
            if (delim_done) begin
              res_valid = 1'b1;
              res_kind  = EV_END;
            end
          end else if (match_r != 6'd0) begin
            // First held byte of the released run is always the CR.
            res_valid = 1'b1;
            res_byte  = CHAR_CR;
            res_last  = start_final;
          end else begin
            res_valid = 1'b1;
            res_byte  = b;
          end
        end
        PH_STOP: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OPEN;
      match_r      <= 6'd0;
      lht_r        <= 1'b0;
      rel_active_r <= 1'b0;
      rel_idx_r    <= 6'd0;
      rel_end_r    <= 6'd0;
      rel_tail_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      match_r      <= match_nxt;
      lht_r        <= lht_nxt;
      rel_active_r <= rel_active_nxt;
      rel_idx_r    <= rel_idx_nxt;
      rel_end_r    <= rel_end_nxt;
      rel_tail_r   <= rel_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_byte_r <= rel_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_kind_r <= skid_kind_r;
        out_byte_r <= skid_byte_r;
        out_last_r <= skid_last_r;
      end else if (res_valid) begin
        out_kind_r <= res_kind;
        out_byte_r <= res_byte;
        out_last_r <= res_last;
      end
    end else if (res_valid) begin
      skid_kind_r <= res_kind;
      skid_byte_r <= res_byte;
      skid_last_r <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_payload_byte = out_byte_r;
  assign out_last         = out_last_r;

  // ---------------------------------------------------------------- assertions
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_stop_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP && !rel_active_r) |-> !res_valid)
    else $error("result produced after the stream stopped");

  a_rel_bound : assert property (@(posedge clk) disable iff (!rst_n)
    rel_active_r |-> (rel_idx_r <= rel_end_r && rel_end_r <= REL_MAX))
    else $error("release index ran past the held bytes");

  a_rel_ends_last : assert property (@(posedge clk) disable iff (!rst_n)
    (rel_go && rel_final) |-> res_last)
    else $error("release finished without marking the final result");

endmodule
